### hdl/slht_pkg.sv
// Shared types and constants for the safety latched hysteresis thermostat.
// Holds the request, result, state and register types and the step codes.
// No dependencies.
package slht_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned FaultW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 19;

  typedef enum logic [KindW-1:0] {
    KIND_TICK    = 3'd0,
    KIND_SET     = 3'd1,
    KIND_LINK    = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_PANIC   = 3'd4,
    KIND_EMERG   = 3'd5,
    KIND_INHIBIT = 3'd6,
    KIND_NONE    = 3'd7
  } kind_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE        = 4'd0,
    FAULT_ELEM_HOT    = 4'd1,
    FAULT_CHAMBER_HOT = 4'd2,
    FAULT_CHAMBER_SNS = 4'd3,
    FAULT_ELEM_SNS    = 4'd4,
    FAULT_LINK        = 4'd5,
    FAULT_PANIC       = 4'd6,
    FAULT_INHIBIT     = 4'd7,
    FAULT_EMERGENCY   = 4'd8
  } fault_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TGT_CEIL     = 3'd0,
    REG_COMMS_TMO    = 3'd1,
    REG_ELEM_CUTOFF  = 3'd2,
    REG_CHAMBER_MAX  = 3'd3,
    REG_HYSTERESIS   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] tgt_ceil;
    logic [18:0] link_tmo;
    logic [15:0] element_cutoff;
    logic [15:0] chamber_max;
    logic [10:0] hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [31:0]      now_ms;
    logic [15:0]      target_centi;
    logic [15:0]      element_temp_centi;
    logic             element_ok;
    logic [15:0]      chamber_temp_centi;
    logic             chamber_ok;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              relay_on;
    logic              fault_latched;
    logic              is_inhibited;
    logic [FaultW-1:0] trip_code;
    logic              heat_mode;
  } res_t;

  typedef struct packed {
    logic [14:0]       target;
    logic              relay;
    logic              latched;
    logic              inhibit;
    logic [FaultW-1:0] fault;
    logic [31:0]       link_stamp;
  } state_t;

  localparam cfg_t CfgReset = '{
    tgt_ceil:       15'd7000,
    link_tmo:       19'd10000,
    element_cutoff: 16'd15000,
    chamber_max:    16'd8000,
    hysteresis:     11'd100
  };

endpackage

### hdl/slht_if.sv
// Request and result channel interfaces for the thermostat.
// Valid/ready handshake; payload widths come from slht_pkg.
interface slht_req_if;
  logic        valid;
  logic        ready;
  logic [slht_pkg::KindW-1:0] kind;
  logic [31:0] now_ms;
  logic [15:0] target_centi;
  logic [15:0] element_temp_centi;
  logic        element_ok;
  logic [15:0] chamber_temp_centi;
  logic        chamber_ok;

  modport source (output valid, kind, now_ms, target_centi, element_temp_centi,
                  element_ok, chamber_temp_centi, chamber_ok, input ready);
  modport sink (input valid, kind, now_ms, target_centi, element_temp_centi,
                element_ok, chamber_temp_centi, chamber_ok, output ready);
endinterface

interface slht_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       relay_on;
  logic       fault_latched;
  logic       is_inhibited;
  logic [slht_pkg::FaultW-1:0] trip_code;
  logic       heat_mode;

  modport source (output valid, status, relay_on, fault_latched, is_inhibited,
                  trip_code, heat_mode, input ready);
  modport sink (input valid, status, relay_on, fault_latched, is_inhibited,
                trip_code, heat_mode, output ready);
endinterface

### hdl/slht_step.sv
// Next-state and result logic for one thermostat request.
// Pure combinational; uses slht_pkg types.
module slht_step (
  input  slht_pkg::req_t   req_i,
  input  slht_pkg::state_t st_i,
  input  slht_pkg::cfg_t   cfg_i,
  output slht_pkg::state_t st_o,
  output slht_pkg::res_t   res_o
);

  logic signed [15:0] elem;
  logic signed [15:0] cham;
  logic signed [15:0] elem_cut;
  logic signed [15:0] cham_max;
  logic signed [16:0] cham_x;
  logic signed [16:0] tgt_x;
  logic signed [16:0] low_x;
  logic [31:0]        elapsed;
  logic               armed;
  logic               trip;
  slht_pkg::fault_e   code;
  logic [14:0]        t_clamp;
  logic               status;

  always_comb begin
    elem     = req_i.element_temp_centi;
    cham     = req_i.chamber_temp_centi;
    elem_cut = cfg_i.element_cutoff;
    cham_max = cfg_i.chamber_max;
    cham_x   = {cham[15], cham};
    tgt_x    = $signed({2'b00, st_i.target});
    low_x    = tgt_x - $signed({6'b0, cfg_i.hysteresis});
    elapsed  = req_i.now_ms - st_i.link_stamp;
    armed    = (st_i.target != 15'd0);

    trip = 1'b1;
    code = slht_pkg::FAULT_NONE;
    if (req_i.element_ok && (elem >= elem_cut)) begin
      code = slht_pkg::FAULT_ELEM_HOT;
    end else if (req_i.chamber_ok && (cham >= cham_max)) begin
      code = slht_pkg::FAULT_CHAMBER_HOT;
    end else if (armed && !req_i.chamber_ok) begin
      code = slht_pkg::FAULT_CHAMBER_SNS;
    end else if (armed && !req_i.element_ok) begin
      code = slht_pkg::FAULT_ELEM_SNS;
    end else if (armed && (elapsed > {13'd0, cfg_i.link_tmo})) begin
      code = slht_pkg::FAULT_LINK;
    end else begin
      trip = 1'b0;
    end

    if (req_i.target_centi[15]) begin
      t_clamp = '0;
    end else if (req_i.target_centi[14:0] > cfg_i.tgt_ceil) begin
      t_clamp = cfg_i.tgt_ceil;
    end else begin
      t_clamp = req_i.target_centi[14:0];
    end

    st_o   = st_i;
    status = 1'b0;
    case (slht_pkg::kind_e'(req_i.kind))
      slht_pkg::KIND_TICK: begin
        if (trip) begin
          st_o.relay   = 1'b0;
          st_o.target  = '0;
          st_o.latched = 1'b1;
          st_o.fault   = code;
        end else if (st_i.latched || !armed) begin
          st_o.relay = 1'b0;
        end else if (!st_i.relay && (cham_x < low_x)) begin
          st_o.relay = 1'b1;
        end else if (st_i.relay && (cham_x >= tgt_x)) begin
          st_o.relay = 1'b0;
        end
      end
      slht_pkg::KIND_SET: begin
        if ((st_i.latched || st_i.inhibit) && (t_clamp != 15'd0)) begin
          status = 1'b1;
        end else begin
          st_o.target = t_clamp;
        end
      end
      slht_pkg::KIND_LINK: st_o.link_stamp = req_i.now_ms;
      slht_pkg::KIND_CLEAR: begin
        if (st_i.inhibit) begin
          status = 1'b1;
        end else begin
          st_o.latched = 1'b0;
          st_o.target  = '0;
          st_o.fault   = slht_pkg::FAULT_NONE;
        end
      end
      slht_pkg::KIND_PANIC: begin
        st_o.target  = '0;
        st_o.latched = 1'b1;
        st_o.fault   = slht_pkg::FAULT_PANIC;
      end
      slht_pkg::KIND_EMERG: begin
        st_o.relay   = 1'b0;
        st_o.target  = '0;
        st_o.latched = 1'b1;
        st_o.fault   = slht_pkg::FAULT_EMERGENCY;
      end
      slht_pkg::KIND_INHIBIT: begin
        st_o.relay   = 1'b0;
        st_o.target  = '0;
        st_o.latched = 1'b1;
        st_o.inhibit = 1'b1;
        st_o.fault   = slht_pkg::FAULT_INHIBIT;
      end
      default: ;
    endcase

    res_o.status        = status;
    res_o.relay_on      = st_o.relay;
    res_o.fault_latched = st_o.latched;
    res_o.is_inhibited  = st_o.inhibit;
    res_o.trip_code     = st_o.fault;
    res_o.heat_mode     = (st_o.target != 15'd0) && !st_o.latched;
  end

endmodule

### hdl/safety_latched_hysteresis_thermostat.sv
// Top level of the safety latched hysteresis thermostat.
// Depends on slht_pkg, slht_if and slht_step.
//
//  channel   dir  handshake          payload
//  req_i     in   valid/ready        kind, now_ms, target_centi, sensor readings
//  res_o     out  valid/ready        status, relay_on, latches, trip_code, heat_mode
//  cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
// Registered path: input register, then the step logic into the result register.
// One request per cycle sustained while results are taken; state is updated as the result register loads.
// Reset clears state, registers to defaults and both valid flags.
// A stalled result holds the input register; ready drops only when both are full.
module safety_latched_hysteresis_thermostat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slht_req_if.sink                      req_i,
  slht_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [slht_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [slht_pkg::CfgDataW-1:0] cfg_wdata_i
);

  slht_pkg::cfg_t   cfg_q;
  slht_pkg::state_t st_q, st_d;
  slht_pkg::req_t   req_q;
  slht_pkg::res_t   res_q, res_d;
  logic             req_vld_q;
  logic             res_vld_q;
  logic             advance;

  assign advance     = req_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !req_vld_q || advance;

  slht_step u_step (
    .req_i (req_q),
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= slht_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (slht_pkg::reg_idx_e'(cfg_idx_i))
        slht_pkg::REG_TGT_CEIL:    cfg_q.tgt_ceil       <= cfg_wdata_i[14:0];
        slht_pkg::REG_COMMS_TMO:   cfg_q.link_tmo       <= cfg_wdata_i;
        slht_pkg::REG_ELEM_CUTOFF: cfg_q.element_cutoff <= cfg_wdata_i[15:0];
        slht_pkg::REG_CHAMBER_MAX: cfg_q.chamber_max    <= cfg_wdata_i[15:0];
        slht_pkg::REG_HYSTERESIS:  cfg_q.hysteresis     <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_vld_q <= req_i.valid;
      end
      if (advance) begin
        st_q      <= st_d;
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.kind               <= req_i.kind;
      req_q.now_ms             <= req_i.now_ms;
      req_q.target_centi       <= req_i.target_centi;
      req_q.element_temp_centi <= req_i.element_temp_centi;
      req_q.element_ok         <= req_i.element_ok;
      req_q.chamber_temp_centi <= req_i.chamber_temp_centi;
      req_q.chamber_ok         <= req_i.chamber_ok;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.status        = res_q.status;
  assign res_o.relay_on      = res_q.relay_on;
  assign res_o.fault_latched = res_q.fault_latched;
  assign res_o.is_inhibited  = res_q.is_inhibited;
  assign res_o.trip_code     = res_q.trip_code;
  assign res_o.heat_mode     = res_q.heat_mode;

endmodule

### hdl/slht_checker.sv
// Port-level checks for the thermostat, attached to the top level by bind.
// Depends on slht_pkg for field widths.
module slht_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic                         fault_latched_i,
  input logic                         is_inhibited_i,
  input logic [slht_pkg::FaultW-1:0]  trip_code_i,
  input logic                         heat_mode_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(trip_code_i)
      && $stable(fault_latched_i) && $stable(heat_mode_i))
    else $error("result changed while stalled");

  a_code_tracks_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (fault_latched_i == (trip_code_i != '0)))
    else $error("fault code disagrees with latch");

  a_inhibit_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_inhibited_i |-> fault_latched_i)
    else $error("inhibited without latch");

  a_heat_unlatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && heat_mode_i |-> !fault_latched_i && !is_inhibited_i)
    else $error("heat mode while latched");

endmodule

bind safety_latched_hysteresis_thermostat slht_checker u_slht_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .fault_latched_i (res_o.fault_latched),
  .is_inhibited_i  (res_o.is_inhibited),
  .trip_code_i     (res_o.trip_code),
  .heat_mode_i     (res_o.heat_mode)
);

### bench/safety_latched_hysteresis_thermostat_tb.sv
// Self-checking bench for safety_latched_hysteresis_thermostat.
// Scoreboards every result against an in-bench thermostat predictor across
// several register settings and handshake idling phases. Needs slht_pkg, slht_if.
module safety_latched_hysteresis_thermostat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [slht_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [slht_pkg::CfgDataW-1:0] cfg_wdata;

  slht_req_if req_if ();
  slht_res_if res_if ();

  safety_latched_hysteresis_thermostat DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor copy of registers and state
  slht_pkg::cfg_t   th_cfg        = slht_pkg::CfgReset;
  logic [14:0]      th_target     = '0;
  logic             th_relay      = 1'b0;
  logic             th_latched    = 1'b0;
  logic             th_inhibit    = 1'b0;
  slht_pkg::fault_e th_fault      = slht_pkg::FAULT_NONE;
  logic [31:0]      th_link_stamp = '0;

  slht_pkg::req_t request_pending_q[$];
  slht_pkg::res_t result_expect_q[$];

  int   src_idle_pct;
  int   snk_stall_pct;
  logic hold_armed;
  int   hold_cnt  = 0;
  int   err_cnt   = 0;
  int   cycle_cnt = 0;
  logic [31:0] gen_now;
  int   gen_tgt;

  wire hold_active = hold_armed && (hold_cnt < HoldCycles);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void latch_trip(slht_pkg::fault_e code, logic drive_off, logic inh);
    if (drive_off) th_relay = 1'b0;
    th_target  = '0;
    th_latched = 1'b1;
    if (inh) th_inhibit = 1'b1;
    th_fault = code;
  endfunction

  function automatic slht_pkg::res_t thermostat_predict(slht_pkg::req_t r);
    slht_pkg::res_t o;
    logic           armed;
    logic           st;
    int             elem;
    int             cham;
    int             t;
    int             lo;
    logic [31:0]    gap;
    st   = 1'b0;
    elem = $signed(r.element_temp_centi);
    cham = $signed(r.chamber_temp_centi);
    case (slht_pkg::kind_e'(r.kind))
      slht_pkg::KIND_TICK: begin
        armed = (th_target != 0);
        gap   = r.now_ms - th_link_stamp;
        if (r.element_ok && elem >= int'($signed(th_cfg.element_cutoff)))
          latch_trip(slht_pkg::FAULT_ELEM_HOT, 1'b1, 1'b0);
        else if (r.chamber_ok && cham >= int'($signed(th_cfg.chamber_max)))
          latch_trip(slht_pkg::FAULT_CHAMBER_HOT, 1'b1, 1'b0);
        else if (armed && !r.chamber_ok)
          latch_trip(slht_pkg::FAULT_CHAMBER_SNS, 1'b1, 1'b0);
        else if (armed && !r.element_ok)
          latch_trip(slht_pkg::FAULT_ELEM_SNS, 1'b1, 1'b0);
        else if (armed && gap > {13'd0, th_cfg.link_tmo})
          latch_trip(slht_pkg::FAULT_LINK, 1'b1, 1'b0);
        else if (th_latched || !armed)
          th_relay = 1'b0;
        else begin
          t  = int'(th_target);
          lo = t - int'(th_cfg.hysteresis);
          if (!th_relay && cham < lo) th_relay = 1'b1;
          else if (th_relay && cham >= t) th_relay = 1'b0;
        end
      end
      slht_pkg::KIND_SET: begin
        t = $signed(r.target_centi);
        if (t < 0) t = 0;
        if (t > int'(th_cfg.tgt_ceil)) t = int'(th_cfg.tgt_ceil);
        if ((th_latched || th_inhibit) && t > 0) st = 1'b1;
        else th_target = t[14:0];
      end
      slht_pkg::KIND_LINK: th_link_stamp = r.now_ms;
      slht_pkg::KIND_CLEAR: begin
        if (th_inhibit) st = 1'b1;
        else begin
          th_latched = 1'b0;
          th_target  = '0;
          th_fault   = slht_pkg::FAULT_NONE;
        end
      end
      slht_pkg::KIND_PANIC:   latch_trip(slht_pkg::FAULT_PANIC, 1'b0, 1'b0);
      slht_pkg::KIND_EMERG:   latch_trip(slht_pkg::FAULT_EMERGENCY, 1'b1, 1'b0);
      slht_pkg::KIND_INHIBIT: latch_trip(slht_pkg::FAULT_INHIBIT, 1'b1, 1'b1);
      default: ;
    endcase
    o.status        = st;
    o.relay_on      = th_relay;
    o.fault_latched = th_latched;
    o.is_inhibited  = th_inhibit;
    o.trip_code     = th_fault;
    o.heat_mode     = (th_target != 0) && !th_latched;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    slht_pkg::req_t cur;
    slht_pkg::req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.kind               = req_if.kind;
        cur.now_ms             = req_if.now_ms;
        cur.target_centi       = req_if.target_centi;
        cur.element_temp_centi = req_if.element_temp_centi;
        cur.element_ok         = req_if.element_ok;
        cur.chamber_temp_centi = req_if.chamber_temp_centi;
        cur.chamber_ok         = req_if.chamber_ok;
        result_expect_q.push_back(thermostat_predict(cur));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (request_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = request_pending_q.pop_front();
          req_if.valid              <= 1'b1;
          req_if.kind               <= nxt.kind;
          req_if.now_ms             <= nxt.now_ms;
          req_if.target_centi       <= nxt.target_centi;
          req_if.element_temp_centi <= nxt.element_temp_centi;
          req_if.element_ok         <= nxt.element_ok;
          req_if.chamber_temp_centi <= nxt.chamber_temp_centi;
          req_if.chamber_ok         <= nxt.chamber_ok;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    slht_pkg::res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (result_expect_q.size() == 0) begin
          report_mismatch("unexpected result, trip_code", res_if.trip_code, -1);
        end else begin
          want = result_expect_q.pop_front();
          if (res_if.status !== want.status)
            report_mismatch("status", res_if.status, want.status);
          if (res_if.relay_on !== want.relay_on)
            report_mismatch("relay_on", res_if.relay_on, want.relay_on);
          if (res_if.fault_latched !== want.fault_latched)
            report_mismatch("fault_latched", res_if.fault_latched, want.fault_latched);
          if (res_if.is_inhibited !== want.is_inhibited)
            report_mismatch("is_inhibited", res_if.is_inhibited, want.is_inhibited);
          if (res_if.trip_code !== want.trip_code)
            report_mismatch("trip_code", res_if.trip_code, want.trip_code);
          if (res_if.heat_mode !== want.heat_mode)
            report_mismatch("heat_mode", res_if.heat_mode, want.heat_mode);
        end
      end
      res_if.ready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (rst_ni && hold_armed && hold_cnt < HoldCycles) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_req(slht_pkg::kind_e k, logic [31:0] now, int tgt, int elem,
                          logic eok, int cham, logic cok);
    slht_pkg::req_t r;
    r.kind               = k;
    r.now_ms             = now;
    r.target_centi       = 16'(tgt);
    r.element_temp_centi = 16'(elem);
    r.element_ok         = eok;
    r.chamber_temp_centi = 16'(cham);
    r.chamber_ok         = cok;
    request_pending_q.push_back(r);
  endtask

  task automatic push_random_requests(int n);
    slht_pkg::req_t r;
    int   pick;
    int   cham;
    int   t;
    int   mx;
    for (int i = 0; i < n; i++) begin
      mx = int'(th_cfg.tgt_ceil);
      pick = $urandom_range(99);
      if ($urandom_range(99) < 2) gen_now = $urandom;
      else gen_now = gen_now + $urandom_range(400);
      r.kind               = slht_pkg::KIND_TICK;
      r.now_ms             = gen_now;
      r.target_centi       = 16'($urandom);
      r.element_temp_centi = 16'($urandom);
      r.element_ok         = 1'($urandom_range(1));
      r.chamber_temp_centi = 16'($urandom);
      r.chamber_ok         = 1'($urandom_range(1));
      if (pick < 10) begin
        // recovery: clear, heartbeat, re-arm
        gen_tgt = (mx > 0) ? $urandom_range(mx, 1) : 0;
        push_req(slht_pkg::KIND_CLEAR, gen_now, $urandom, $urandom, 1'b1, $urandom, 1'b1);
        push_req(slht_pkg::KIND_LINK, gen_now, $urandom, $urandom, 1'b1, $urandom, 1'b1);
        r.kind         = slht_pkg::KIND_SET;
        r.target_centi = 16'(gen_tgt);
      end else if (pick < 45) begin
        cham = gen_tgt + $urandom_range(600) - 400;
        r.chamber_temp_centi = 16'(cham);
        r.element_temp_centi = 16'(cham + $urandom_range(3000));
        r.element_ok = ($urandom_range(99) < 97);
        r.chamber_ok = ($urandom_range(99) < 97);
      end else if (pick < 60) begin
        r.kind = slht_pkg::KIND_LINK;
      end else if (pick < 70) begin
        r.kind = slht_pkg::KIND_SET;
        if ($urandom_range(99) < 70) begin
          t = $urandom_range(mx + 200);
          r.target_centi = 16'(t);
          gen_tgt = (t > mx) ? mx : t;
        end
      end else if (pick < 75) begin
        r.kind = slht_pkg::KIND_CLEAR;
      end else if (pick < 78) begin
        r.kind = slht_pkg::KIND_PANIC;
      end else if (pick < 80) begin
        r.kind = slht_pkg::KIND_EMERG;
      end else if (pick < 82) begin
        r.kind = slht_pkg::KIND_NONE;
      end else begin
        // noise; inhibit is kept for the end of the run
        r.kind   = 3'($urandom_range(7));
        r.now_ms = $urandom;
        if (slht_pkg::kind_e'(r.kind) == slht_pkg::KIND_INHIBIT) r.kind = slht_pkg::KIND_TICK;
      end
      request_pending_q.push_back(r);
    end
  endtask

  task automatic load_cfg(slht_pkg::cfg_t c);
    th_cfg = c;
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= slht_pkg::REG_TGT_CEIL; cfg_wdata <= 19'(c.tgt_ceil);
    @(posedge clk_i);
    cfg_idx <= slht_pkg::REG_COMMS_TMO;   cfg_wdata <= c.link_tmo;
    @(posedge clk_i);
    cfg_idx <= slht_pkg::REG_ELEM_CUTOFF; cfg_wdata <= 19'(c.element_cutoff);
    @(posedge clk_i);
    cfg_idx <= slht_pkg::REG_CHAMBER_MAX; cfg_wdata <= 19'(c.chamber_max);
    @(posedge clk_i);
    cfg_idx <= slht_pkg::REG_HYSTERESIS;  cfg_wdata <= 19'(c.hysteresis);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int src, int snk);
    @(posedge clk_i);
    src_idle_pct  <= src;
    snk_stall_pct <= snk;
  endtask

  // sampled at the falling edge so that driver updates have settled
  task automatic wait_drained();
    while (request_pending_q.size() != 0 || req_if.valid || result_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    slht_pkg::cfg_t c;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = slht_pkg::REG_TGT_CEIL;
    cfg_wdata     = '0;
    req_if.valid  = 1'b0;
    req_if.kind   = slht_pkg::KIND_TICK;
    req_if.now_ms = '0;
    req_if.target_centi       = '0;
    req_if.element_temp_centi = '0;
    req_if.element_ok         = 1'b0;
    req_if.chamber_temp_centi = '0;
    req_if.chamber_ok         = 1'b0;
    res_if.ready  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_armed    = 1'b0;
    gen_now       = 32'd30000;
    gen_tgt       = 5000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass on reset register values
    push_req(slht_pkg::KIND_TICK,  0,     0, 0,     1'b0, 0,     1'b0);
    push_req(slht_pkg::KIND_SET,   0,    -5, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   0, 32767, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_LINK,  1000,  0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  2000,  0, 9000,  1'b1, 6800,  1'b1);
    push_req(slht_pkg::KIND_TICK,  2100,  0, 9000,  1'b1, 7000,  1'b1);
    push_req(slht_pkg::KIND_TICK,  2200,  0, 9000,  1'b1, 6900,  1'b1);
    push_req(slht_pkg::KIND_TICK,  2300,  0, 9000,  1'b1, 6899,  1'b1);
    push_req(slht_pkg::KIND_TICK,  11000, 0, 9000,  1'b1, 6899,  1'b1);
    push_req(slht_pkg::KIND_PANIC, 11000, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   11000, 100, 0,   1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_EMERG, 11000, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   11000, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_CLEAR, 11000, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   12000, 5000, 0,  1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_LINK,  12000, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  12100, 0, 15000, 1'b1, 8000,  1'b1);
    push_req(slht_pkg::KIND_CLEAR, 12100, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   12100, 5000, 0,  1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  12200, 0, 14999, 1'b1, 8000,  1'b1);
    push_req(slht_pkg::KIND_SET,   12200, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_CLEAR, 12200, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   12200, 5000, 0,  1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  12300, 0, 20000, 1'b0, 4000,  1'b0);
    push_req(slht_pkg::KIND_CLEAR, 12300, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   12300, 5000, 0,  1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  12400, 0, 20000, 1'b0, 4000,  1'b1);
    push_req(slht_pkg::KIND_CLEAR, 12400, 0, 0,     1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_SET,   12400, 5000, 0,  1'b1, 0,     1'b1);
    push_req(slht_pkg::KIND_TICK,  22001, 0, 9000,  1'b1, 4000,  1'b1);
    push_req(slht_pkg::KIND_NONE,  22001, 0, 0,     1'b1, 0,     1'b1);
    push_random_requests(200);
    wait_drained();

    // wide limits, sender idling
    c = '{tgt_ceil: 15'd20000, link_tmo: 19'd300000, element_cutoff: 16'sd25000,
          chamber_max: 16'sd25000, hysteresis: 11'd2000};
    load_cfg(c);
    set_idling(65, 0);
    push_random_requests(280);
    wait_drained();

    // low extremes, receiver stalling
    c = '{tgt_ceil: 15'd0, link_tmo: 19'd1, element_cutoff: -16'sd5000,
          chamber_max: -16'sd5000, hysteresis: 11'd0};
    load_cfg(c);
    set_idling(0, 65);
    push_random_requests(120);
    wait_drained();

    // register values past their ranges, now_ms wrapping, long receiver hold-off
    c = '{tgt_ceil: 15'h7FFF, link_tmo: 19'h7FFFF, element_cutoff: 16'sh7FFF,
          chamber_max: 16'sh7FFF, hysteresis: 11'h7FF};
    load_cfg(c);
    set_idling(7, 7);
    gen_now = 32'hFFFF_F000;
    push_req(slht_pkg::KIND_LINK, gen_now, 0, 0, 1'b1, 0, 1'b1);
    push_random_requests(280);
    @(posedge clk_i);
    hold_armed <= 1'b1;
    wait_drained();

    // random in-range settings, no idling
    c.tgt_ceil       = 15'($urandom_range(20000));
    c.link_tmo       = 19'($urandom_range(300000, 1));
    c.element_cutoff = 16'($urandom_range(30000) - 5000);
    c.chamber_max    = 16'($urandom_range(25000, 3000));
    c.hysteresis     = 11'($urandom_range(2000));
    load_cfg(c);
    set_idling(0, 0);
    push_random_requests(280);
    wait_drained();

    // back to reset values, then the permanent inhibit
    load_cfg(slht_pkg::CfgReset);
    set_idling(7, 7);
    push_random_requests(140);
    push_req(slht_pkg::KIND_INHIBIT, gen_now, 0, 0,  1'b1, 0,    1'b1);
    push_req(slht_pkg::KIND_SET,     gen_now, 100, 0, 1'b1, 0,   1'b1);
    push_req(slht_pkg::KIND_SET,     gen_now, 0, 0,  1'b1, 0,    1'b1);
    push_req(slht_pkg::KIND_CLEAR,   gen_now, 0, 0,  1'b1, 0,    1'b1);
    push_req(slht_pkg::KIND_TICK,    gen_now, 0, 0,  1'b1, 1000, 1'b1);
    push_req(slht_pkg::KIND_PANIC,   gen_now, 0, 0,  1'b1, 0,    1'b1);
    push_req(slht_pkg::KIND_NONE,    gen_now, 0, 0,  1'b1, 0,    1'b1);
    wait_drained();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
